### hw/rtl/crcfb_pkg.sv
// Package for the CRC-16 frame builder: frame constants, queue entry type,
// back-end phase type and the byte-wide CRC update. No dependencies.
`timescale 1ns / 1ps

package crcfb_pkg;

  localparam int PAYLOAD_BYTES = 21;

  localparam logic [7:0] LAST_POS  = 8'(PAYLOAD_BYTES - 1);
  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] LEN_BYTE  = 8'((PAYLOAD_BYTES + 5) % 256);
  localparam logic [7:0] HDR_ZERO  = 8'h00;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } entry_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_SYNC,
    PH_LEN,
    PH_ZERO,
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_t;

  // One byte through the reflected CRC-16, LSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/crc16_frame_builder.sv
// Channel   Valid          Stall          Data
// input     payload_valid  payload_stall  payload_byte
// output    frame_valid    frame_stall    frame_byte, frame_end
//
// Each payload byte produces one output byte per cycle while frame_stall is low;
// a frame's first byte adds three header bytes and its last two CRC bytes, so 21
// bytes give 26 output bytes. The back end's single output register sets that pace.
// Input bytes are taken every cycle while the four-entry queue has room.
// Reset is synchronous and returns the block to the start of a frame.
// Top level of the CRC-16 frame builder; depends on crcfb_pkg and the
// crcfb_front, crcfb_queue and crcfb_back modules.
`timescale 1ns / 1ps

module crc16_frame_builder (
  input  logic       clk,
  input  logic       rst,
  input  logic       payload_valid,
  output logic       payload_stall,
  input  logic [7:0] payload_byte,
  output logic       frame_valid,
  input  logic       frame_stall,
  output logic [7:0] frame_byte,
  output logic       frame_end
);
  import crcfb_pkg::*;

  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   queue_full;
  logic   pop;
  logic   head_valid;

  crcfb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .payload_valid (payload_valid),
    .payload_stall (payload_stall),
    .payload_byte  (payload_byte),
    .queue_full    (queue_full),
    .push          (push),
    .push_entry    (push_entry)
  );

  crcfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head       (head),
    .not_empty  (head_valid)
  );

  crcfb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_byte  (frame_byte),
    .frame_end   (frame_end)
  );

endmodule

### hw/rtl/crcfb_queue.sv
// Small FIFO of classified payload bytes between the front and back ends.
// Depends on crcfb_pkg for the entry type and depth.
`timescale 1ns / 1ps

module crcfb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  crcfb_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output crcfb_pkg::entry_t head,
  output logic            not_empty
);
  import crcfb_pkg::*;

  entry_t               mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_CW-1:0]  count;
  logic                 do_push;
  logic                 do_pop;

  assign full      = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/crcfb_front.sv
// Front end: accepts payload bytes and marks the first and last of each frame.
// Depends on crcfb_pkg for the frame length and entry type.
`timescale 1ns / 1ps

module crcfb_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            payload_valid,
  output logic            payload_stall,
  input  logic [7:0]      payload_byte,
  input  logic            queue_full,
  output logic            push,
  output crcfb_pkg::entry_t push_entry
);
  import crcfb_pkg::*;

  logic [7:0] position;
  logic       last;

  // A position at or past the final slot closes the frame.
  assign last          = (position >= LAST_POS);
  assign payload_stall = queue_full;
  assign push          = payload_valid && !queue_full;

  assign push_entry.data  = payload_byte;
  assign push_entry.first = (position == 8'd0);
  assign push_entry.last  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= 8'd0;
    end else if (push) begin
      position <= last ? 8'd0 : position + 8'd1;
    end
  end

endmodule

### hw/rtl/crcfb_back.sv
// Back end: expands queued bytes into header, payload and CRC output bytes.
// Depends on crcfb_pkg for constants, phase type and the CRC function.
`timescale 1ns / 1ps

module crcfb_back (
  input  logic            clk,
  input  logic            rst,
  input  crcfb_pkg::entry_t head,
  input  logic            head_valid,
  output logic            pop,
  output logic            frame_valid,
  input  logic            frame_stall,
  output logic [7:0]      frame_byte,
  output logic            frame_end
);
  import crcfb_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  phase_t      phase_cur;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [15:0] crc_base;
  logic [7:0]  byte_sel;
  logic        end_sel;
  logic        feed;
  logic        load;

  // With an entry queued, the output register loads when empty or draining.
  assign load = head_valid && (!frame_valid || !frame_stall);

  always_comb begin
    phase_cur = phase;
    if (phase == PH_START) begin
      phase_cur = head.first ? PH_SYNC : PH_DATA;
    end

    byte_sel   = head.data;
    end_sel    = 1'b0;
    feed       = 1'b0;
    pop        = 1'b0;
    phase_next = phase;
    crc_base   = crc;

    case (phase_cur)
      PH_SYNC: begin
        byte_sel   = SYNC_BYTE;
        crc_base   = CRC_INIT;
        feed       = 1'b1;
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        byte_sel   = LEN_BYTE;
        feed       = 1'b1;
        phase_next = PH_ZERO;
      end
      PH_ZERO: begin
        byte_sel   = HDR_ZERO;
        feed       = 1'b1;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        byte_sel = head.data;
        feed     = 1'b1;
        if (head.last) begin
          phase_next = PH_CRC_LO;
        end else begin
          phase_next = PH_START;
          pop        = load;
        end
      end
      PH_CRC_LO: begin
        byte_sel   = ~crc[7:0];
        phase_next = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        byte_sel   = ~crc[15:8];
        end_sel    = 1'b1;
        phase_next = PH_START;
        pop        = load;
      end
      default: begin
        phase_next = PH_START;
      end
    endcase

    crc_next = feed ? crc_feed(crc_base, byte_sel) : crc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      crc   <= CRC_INIT;
    end else if (load) begin
      phase <= phase_next;
      crc   <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (load) begin
      frame_valid <= 1'b1;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte <= byte_sel;
      frame_end  <= end_sel;
    end
  end

endmodule
